@@ rtl/fiscal_frame_encoder_top_macros.svh @@
// Assertion macros shared by the frame encoder modules.
// Each macro expects clk and arst_n to be visible at the place of use.
`ifndef FISCAL_FRAME_ENCODER_TOP_MACROS_SVH
`define FISCAL_FRAME_ENCODER_TOP_MACROS_SVH

// Clocked property, switched off while reset is asserted.
`define FFE_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Condition that must never be seen at a clock edge.
`define FFE_NEVER(lbl, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(expr)) else $error(msg);

`endif

@@ rtl/ffe_pkg.sv @@
// Types and constants of the fiscal frame encoder.
// Used by every module of the block; depends on nothing else.
package ffe_pkg;

	localparam logic [7:0] MAX_PAYLOAD = 8'd219;
	localparam logic [7:0] PREAMBLE    = 8'h01;
	localparam logic [7:0] POSTAMBLE   = 8'h05;
	localparam logic [7:0] TERMINATOR  = 8'h03;
	localparam logic [7:0] LEN_OFFSET  = 8'h24;
	localparam logic [7:0] CHECK_BASE  = 8'h30;
	localparam logic [6:0] SEQ_RESET   = 7'h31;
	localparam logic [6:0] SEQ_LOW     = 7'h20;
	localparam logic [6:0] SEQ_HIGH    = 7'h7f;

	typedef struct packed {
		logic [7:0] command_code;
		logic [7:0] payload_length;
		logic [7:0] data_byte;
		logic       last_byte;
	} in_item_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       last_of_run;
	} out_item_t;

	// One classified request as passed from the front to the back.
	typedef struct packed {
		logic       header;
		logic       has_data;
		logic       trailer;
		logic [7:0] len_byte;
		logic [7:0] cmd;
		logic [7:0] data;
	} job_t;

endpackage

@@ rtl/fiscal_frame_encoder_top.sv @@
// Top level of the fiscal frame encoder: front, job queue and back.
// Depends on ffe_pkg, ffe_front, ffe_queue and ffe_back.
//
//   channel  direction  handshake             payload
//   req      in         req_valid/req_ready   in_item_t  (one payload request)
//   rsp      out        rsp_valid/rsp_ready   out_item_t (one frame byte)
//
// The back end emits one byte per clock while it holds a job and the response side is ready.
// A data request yields one byte; the first request of a frame adds four header
// bytes and the closing request six trailer bytes, so throughput is set by the
// single byte sequencer in the back end.
// Requests are taken whenever the job queue has room (QUEUE_DEPTH entries). Short
// header and trailer bursts are absorbed there; a run of short frames outpaces the
// sequencer, fills the queue and holds req_ready low until bytes drain.
// Reset is asynchronous and active low; it returns the encoder to the idle state
// with sequence number 0x31 and an empty queue. No clearing pass is needed.
module fiscal_frame_encoder_top import ffe_pkg::*; #(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      req_valid,
	output logic      req_ready,
	input  in_item_t  req,
	output logic      rsp_valid,
	input  logic      rsp_ready,
	output out_item_t rsp
);

	job_t front_job;
	job_t head_job;
	logic q_full;
	logic q_not_empty;
	logic q_pop;
	logic req_accept;

	// A request is accepted whenever there is room for its job in the queue.
	assign req_ready  = !q_full;
	assign req_accept = req_valid && req_ready;

	// The front tracks frame boundaries and turns each request into a job.
	ffe_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.accept (req_accept),
		.req    (req),
		.job    (front_job)
	);

	// The queue decouples request acceptance from byte emission.
	ffe_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (req_accept),
		.push_job  (front_job),
		.full      (q_full),
		.pop       (q_pop),
		.not_empty (q_not_empty),
		.head      (head_job)
	);

	// The back sequences frame bytes into a registered response stage.
	ffe_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (q_not_empty),
		.q_job     (head_job),
		.q_pop     (q_pop),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

endmodule

@@ rtl/ffe_front.sv @@
// Front end: accepts requests and classifies them into jobs.
// Depends on ffe_pkg.
module ffe_front import ffe_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     accept,
	input  in_item_t req,
	output job_t     job
);

	logic       in_frame_q;
	logic [7:0] len_sat;

	always_comb begin
		len_sat = (req.payload_length > MAX_PAYLOAD) ? MAX_PAYLOAD : req.payload_length;
		job.header   = !in_frame_q;
		job.len_byte = len_sat + LEN_OFFSET;
		job.cmd      = req.command_code;
		job.data     = req.data_byte;
		if (!in_frame_q) begin
			// An empty payload has no data byte and always closes the frame.
			job.has_data = (len_sat != 8'd0);
			job.trailer  = (len_sat == 8'd0) || req.last_byte;
		end else begin
			job.has_data = 1'b1;
			job.trailer  = req.last_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_frame_q <= 1'b0;
		end else if (accept) begin
			in_frame_q <= !job.trailer;
		end
	end

endmodule

@@ rtl/ffe_queue.sv @@
// Short job queue between the front and the back of the encoder.
// Depends on ffe_pkg and the assertion macro header.
`include "fiscal_frame_encoder_top_macros.svh"
module ffe_queue import ffe_pkg::*; #(
	parameter int DEPTH = 4
) (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  job_t push_job,
	output logic full,
	input  logic pop,
	output logic not_empty,
	output job_t head
);

	localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [IW-1:0] LAST_IDX = IW'(DEPTH - 1);
	localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

	job_t          mem_q [DEPTH];
	logic [IW-1:0] wr_ptr_q;
	logic [IW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;

	assign full      = (count_q == FULL_CNT);
	assign not_empty = (count_q != '0);
	assign head      = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_IDX) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_IDX) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	`FFE_NEVER(a_count_bound, count_q > FULL_CNT, "queue fill count above depth")
	`FFE_ASSERT(a_pop_dec, pop && !push |=> count_q == $past(count_q) - 1'b1, "pop lost")
	`FFE_ASSERT(a_push_inc, push && !pop |=> count_q == $past(count_q) + 1'b1, "push lost")

endmodule

@@ rtl/ffe_back.sv @@
// Back end: steps through the bytes of each job, keeps sequence and check sum.
// Depends on ffe_pkg and the assertion macro header.
`include "fiscal_frame_encoder_top_macros.svh"
module ffe_back import ffe_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      q_valid,
	input  job_t      q_job,
	output logic      q_pop,
	output logic      rsp_valid,
	input  logic      rsp_ready,
	output out_item_t rsp
);

	localparam logic [3:0] ST_PRE  = 4'd0;
	localparam logic [3:0] ST_LEN  = 4'd1;
	localparam logic [3:0] ST_SEQ  = 4'd2;
	localparam logic [3:0] ST_CMD  = 4'd3;
	localparam logic [3:0] ST_DATA = 4'd4;
	localparam logic [3:0] ST_POST = 4'd5;
	localparam logic [3:0] ST_C3   = 4'd6;
	localparam logic [3:0] ST_C2   = 4'd7;
	localparam logic [3:0] ST_C1   = 4'd8;
	localparam logic [3:0] ST_C0   = 4'd9;
	localparam logic [3:0] ST_TERM = 4'd10;

	job_t       job_q;
	logic       busy_q;
	logic [3:0] step_q;
	logic [6:0] seq_q;
	logic [15:0] sum_q;

	logic       emit;
	logic       final_step;
	logic       add_sum;
	logic [3:0] next_step;
	logic [7:0] cur_byte;

	assign emit  = busy_q && (!rsp_valid || rsp_ready);
	assign q_pop = q_valid && (!busy_q || (emit && final_step));

	always_comb begin
		next_step  = step_q;
		final_step = 1'b0;
		add_sum    = 1'b0;
		cur_byte   = TERMINATOR;
		unique case (step_q)
			ST_PRE: begin
				cur_byte  = PREAMBLE;
				next_step = ST_LEN;
			end
			ST_LEN: begin
				cur_byte  = job_q.len_byte;
				add_sum   = 1'b1;
				next_step = ST_SEQ;
			end
			ST_SEQ: begin
				cur_byte  = {1'b0, seq_q};
				add_sum   = 1'b1;
				next_step = ST_CMD;
			end
			ST_CMD: begin
				cur_byte   = job_q.cmd;
				add_sum    = 1'b1;
				next_step  = job_q.has_data ? ST_DATA : ST_POST;
				final_step = !job_q.has_data && !job_q.trailer;
			end
			ST_DATA: begin
				cur_byte   = job_q.data;
				add_sum    = 1'b1;
				next_step  = ST_POST;
				final_step = !job_q.trailer;
			end
			ST_POST: begin
				cur_byte  = POSTAMBLE;
				add_sum   = 1'b1;
				next_step = ST_C3;
			end
			ST_C3: begin
				cur_byte  = CHECK_BASE + {4'h0, sum_q[15:12]};
				next_step = ST_C2;
			end
			ST_C2: begin
				cur_byte  = CHECK_BASE + {4'h0, sum_q[11:8]};
				next_step = ST_C1;
			end
			ST_C1: begin
				cur_byte  = CHECK_BASE + {4'h0, sum_q[7:4]};
				next_step = ST_C0;
			end
			ST_C0: begin
				cur_byte  = CHECK_BASE + {4'h0, sum_q[3:0]};
				next_step = ST_TERM;
			end
			ST_TERM: begin
				cur_byte   = TERMINATOR;
				final_step = 1'b1;
			end
			default: begin
				cur_byte   = TERMINATOR;
				final_step = 1'b1;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q    <= 1'b0;
			step_q    <= ST_PRE;
			seq_q     <= SEQ_RESET;
			sum_q     <= '0;
			rsp_valid <= 1'b0;
		end else begin
			if (q_pop) begin
				busy_q <= 1'b1;
				step_q <= q_job.header ? ST_PRE : ST_DATA;
			end else if (emit && final_step) begin
				busy_q <= 1'b0;
			end else if (emit) begin
				step_q <= next_step;
			end

			if (emit) begin
				if (step_q == ST_PRE) begin
					// A new frame: fresh sum, sequence advanced before use.
					sum_q <= '0;
					seq_q <= (seq_q == SEQ_HIGH) ? SEQ_LOW : seq_q + 1'b1;
				end else if (add_sum) begin
					sum_q <= sum_q + {8'h00, cur_byte};
				end
			end

			if (emit) begin
				rsp_valid <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			job_q <= q_job;
		end
		if (emit) begin
			rsp.out_byte    <= cur_byte;
			rsp.last_of_run <= final_step;
		end
	end

	`FFE_ASSERT(a_sum_cleared, emit && step_q == ST_PRE |=> sum_q == 16'h0000, "sum not cleared")
	`FFE_NEVER(a_seq_range, seq_q < SEQ_LOW, "sequence number below its range")
	`FFE_ASSERT(a_term_last, emit && step_q == ST_TERM |=> rsp_valid && rsp.last_of_run,
		"terminator not marked as end of run")

endmodule
